FILE: sv/ilap_pkg.sv
// ----------------------------------------------------------------------------
// ilap_pkg
// Shared types and constants for the in-order load/ALU pipeline: field
// layout of the stream beats, function and opcode codes, and the classified
// item that the front end hands to the back end.
// ----------------------------------------------------------------------------
package ilap_pkg;

    // field widths
    localparam int IDX_W  = 3;
    localparam int OP_W   = 3;
    localparam int FUNC_W = 2;
    localparam int VAL_W  = 64;
    localparam int WORD_W = 32;

    // input beat layout: tuser = {instr_valid, func}
    localparam int S_TUSER_W     = 3;
    localparam int S_TDATA_W     = 80;
    localparam int S_OPCODE_LSB  = 0;
    localparam int S_DEST_LSB    = 3;
    localparam int S_SRC1_LSB    = 6;
    localparam int S_SRC2_LSB    = 9;
    localparam int S_PIDX_LSB    = 12;
    localparam int S_PVAL_LSB    = 15;
    localparam int S_FUNC_LSB    = 0;
    localparam int S_IVALID_BIT  = 2;

    // output beat layout: tuser = wb_valid, tdata = {pad, busy_res, wb_value, wb_reg}
    localparam int M_TUSER_W     = 1;
    localparam int M_TDATA_W     = 72;
    localparam int M_PAD_W       = M_TDATA_W - IDX_W - VAL_W - 1;

    // item functions
    localparam logic [FUNC_W-1:0] FUNC_STEP    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRE_REG = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRE_MEM = 2'd2;

    // opcodes; anything above OP_LD passes the destination register through
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_AND = 3'd2;
    localparam logic [OP_W-1:0] OP_OR  = 3'd3;
    localparam logic [OP_W-1:0] OP_LD  = 3'd4;

    // classified item, front end to back end
    typedef struct packed {
        logic             step;       // advance the pipeline
        logic             pre_reg;    // preload a register
        logic             pre_mem;    // preload a memory word
        logic             new_instr;  // step brings an instruction into decode
        logic             is_load;    // that instruction is a load
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] src1;
        logic [IDX_W-1:0] src2;
        logic [IDX_W-1:0] pidx;
        logic [VAL_W-1:0] pval;
    } item_t;

endpackage

FILE: sv/ilap_front.sv
// ----------------------------------------------------------------------------
// ilap_front
// Input side: unpacks each beat, classifies it (step, register preload,
// memory preload, no-op; load or ALU instruction) and holds it in a
// two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module ilap_front
    import ilap_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 head_valid,
    output item_t                head,
    input  logic                 head_pop
);

    item_t             in_item;
    logic [FUNC_W-1:0] func;
    logic              push;

    item_t             q_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;

    // unpack and classify the incoming beat
    assign func = s_tuser[S_FUNC_LSB +: FUNC_W];

    always_comb begin
        in_item.step    = 1'b0;
        in_item.pre_reg = 1'b0;
        in_item.pre_mem = 1'b0;
        unique case (func)
            FUNC_STEP:    in_item.step    = 1'b1;
            FUNC_PRE_REG: in_item.pre_reg = 1'b1;
            FUNC_PRE_MEM: in_item.pre_mem = 1'b1;
            default:      ;
        endcase
        in_item.op        = s_tdata[S_OPCODE_LSB +: OP_W];
        in_item.dest      = s_tdata[S_DEST_LSB +: IDX_W];
        in_item.src1      = s_tdata[S_SRC1_LSB +: IDX_W];
        in_item.src2      = s_tdata[S_SRC2_LSB +: IDX_W];
        in_item.pidx      = s_tdata[S_PIDX_LSB +: IDX_W];
        in_item.pval      = s_tdata[S_PVAL_LSB +: VAL_W];
        in_item.new_instr = in_item.step && s_tuser[S_IVALID_BIT];
        in_item.is_load   = (in_item.op == OP_LD);
    end

    // two-entry queue
    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (head_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(head_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/ilap_back.sv
// ----------------------------------------------------------------------------
// ilap_back
// Execution side: reads the register file and data memory as an item leaves
// the queue, then carries out one pipeline step (retire, load, ALU, address,
// issue, decode) or one preload, and registers the result beat.
// ----------------------------------------------------------------------------
module ilap_back
    import ilap_pkg::*;
#(
    parameter int NUM_REGS       = 8,
    parameter int DATA_WORDS     = 8,
    parameter int WB_QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  item_t                head,
    output logic                 head_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int RF_AW = $clog2(NUM_REGS);
    localparam int DM_AW = $clog2(DATA_WORDS);
    localparam int CNT_W = $clog2(WB_QUEUE_DEPTH + 1);
    localparam int QI_W  = $clog2(WB_QUEUE_DEPTH);

    // ---------------- helpers
    function automatic logic reg_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < NUM_REGS;
    endfunction

    function automatic logic mem_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < DATA_WORDS;
    endfunction

    // register value after this step's retire: retire, then the write made
    // while the read was in flight, then the array
    function automatic logic [VAL_W-1:0] rf_resolve(
        input logic [IDX_W-1:0] idx,
        input logic [VAL_W-1:0] rdata,
        input logic             rvld,
        input logic             wr_we,
        input logic [IDX_W-1:0] wr_idx,
        input logic [VAL_W-1:0] wr_val,
        input logic             fw_we,
        input logic [IDX_W-1:0] fw_idx,
        input logic [VAL_W-1:0] fw_val
    );
        logic [VAL_W-1:0] v;
        if (!reg_ok(idx)) begin
            v = '0;
        end else if (wr_we && (wr_idx == idx)) begin
            v = wr_val;
        end else if (fw_we && (fw_idx == idx)) begin
            v = fw_val;
        end else if (rvld) begin
            v = rdata;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    // ---------------- execute register
    logic  x_valid_reg;
    item_t x_item_reg;
    logic  adv_x;
    logic  exec_step;

    // ---------------- storage
    logic [VAL_W-1:0]    rfa_mem [NUM_REGS];
    logic [VAL_W-1:0]    rfb_mem [NUM_REGS];
    logic [WORD_W-1:0]   dm_mem  [DATA_WORDS];
    logic [NUM_REGS-1:0]   rf_vld_reg;
    logic [DATA_WORDS-1:0] dm_vld_reg;

    logic [VAL_W-1:0]  rd1_data_reg, rd2_data_reg, rdb_data_reg;
    logic              rd1_vld_reg, rd2_vld_reg, rdb_vld_reg;
    logic [WORD_W-1:0] dm_data_reg;
    logic              dm_rvld_reg;

    // writes that landed in the same cycle as the read
    logic              rff_we_reg;
    logic [IDX_W-1:0]  rff_idx_reg;
    logic [VAL_W-1:0]  rff_val_reg;
    logic              dmf_we_reg;
    logic [IDX_W-1:0]  dmf_idx_reg;
    logic [WORD_W-1:0] dmf_val_reg;

    // ---------------- pipeline slots
    logic             dec_vld_reg, dec_vld_next;
    logic             dec_ld_reg, dec_ld_next;
    logic [OP_W-1:0]  dec_op_reg, dec_op_next;
    logic [IDX_W-1:0] dec_dest_reg, dec_dest_next;
    logic [VAL_W-1:0] dec_a_reg, dec_a_next;
    logic [VAL_W-1:0] dec_b_reg, dec_b_next;

    logic             alu_vld_reg, alu_vld_next;
    logic [OP_W-1:0]  alu_op_reg, alu_op_next;
    logic [IDX_W-1:0] alu_dest_reg, alu_dest_next;
    logic [VAL_W-1:0] alu_a_reg, alu_a_next;
    logic [VAL_W-1:0] alu_b_reg, alu_b_next;

    // only the low address bits of the operands matter
    logic             agu_vld_reg, agu_vld_next;
    logic [IDX_W-1:0] agu_dest_reg, agu_dest_next;
    logic [IDX_W-1:0] agu_a_reg, agu_a_next;
    logic [IDX_W-1:0] agu_b_reg, agu_b_next;

    logic             ld_vld_reg, ld_vld_next;
    logic [IDX_W-1:0] ld_dest_reg, ld_dest_next;
    logic [IDX_W-1:0] ld_addr_reg, ld_addr_next;

    // ---------------- write-back queue (head at entry 0)
    logic [IDX_W-1:0] wbq_idx_reg [WB_QUEUE_DEPTH];
    logic [IDX_W-1:0] wbq_idx_next [WB_QUEUE_DEPTH];
    logic [VAL_W-1:0] wbq_val_reg [WB_QUEUE_DEPTH];
    logic [VAL_W-1:0] wbq_val_next [WB_QUEUE_DEPTH];
    logic [CNT_W-1:0] wbq_cnt_reg, wbq_cnt_next;
    logic [CNT_W-1:0] cnt0, cnt1;

    // ---------------- step datapath
    logic             ret, ret_we;
    logic [IDX_W-1:0] ret_idx;
    logic [VAL_W-1:0] ret_val;
    logic             pre_we;
    logic             rf_we;
    logic [IDX_W-1:0] rf_widx;
    logic [VAL_W-1:0] rf_wval;
    logic             dm_we;
    logic [VAL_W-1:0] src1_v, src2_v, pass_v;
    logic [WORD_W-1:0] ld_word;
    logic [VAL_W-1:0] ld_value;
    logic [VAL_W-1:0] alu_res;
    logic             busy_next;

    // ---------------- output register
    logic             m_valid_reg;
    logic             m_wbv_reg;
    logic [IDX_W-1:0] m_wbr_reg;
    logic [VAL_W-1:0] m_wbval_reg;
    logic             m_busy_reg;

    // flow control
    assign adv_x     = x_valid_reg && (!m_valid_reg || m_tready);
    assign head_pop  = head_valid && (!x_valid_reg || adv_x);
    assign exec_step = adv_x && x_item_reg.step;

    // retire and register file write port
    assign ret     = exec_step && (wbq_cnt_reg != '0);
    assign ret_idx = wbq_idx_reg[0];
    assign ret_val = wbq_val_reg[0];
    assign ret_we  = ret && reg_ok(ret_idx);
    assign pre_we  = adv_x && x_item_reg.pre_reg && reg_ok(x_item_reg.pidx);
    assign rf_we   = ret_we || pre_we;
    assign rf_widx = ret_we ? ret_idx : x_item_reg.pidx;
    assign rf_wval = ret_we ? ret_val : x_item_reg.pval;
    assign dm_we   = adv_x && x_item_reg.pre_mem && mem_ok(x_item_reg.pidx);

    // operand values after retire
    assign src1_v = rf_resolve(x_item_reg.src1, rd1_data_reg, rd1_vld_reg, ret_we, ret_idx,
                               ret_val, rff_we_reg, rff_idx_reg, rff_val_reg);
    assign src2_v = rf_resolve(x_item_reg.src2, rd2_data_reg, rd2_vld_reg, ret_we, ret_idx,
                               ret_val, rff_we_reg, rff_idx_reg, rff_val_reg);
    assign pass_v = rf_resolve(alu_dest_reg, rdb_data_reg, rdb_vld_reg, ret_we, ret_idx,
                               ret_val, rff_we_reg, rff_idx_reg, rff_val_reg);

    // load word, sign-extended
    always_comb begin
        if (!mem_ok(ld_addr_reg)) begin
            ld_word = '0;
        end else if (dmf_we_reg && (dmf_idx_reg == ld_addr_reg)) begin
            ld_word = dmf_val_reg;
        end else if (dm_rvld_reg) begin
            ld_word = dm_data_reg;
        end else begin
            ld_word = '0;
        end
        ld_value = {{(VAL_W - WORD_W){ld_word[WORD_W-1]}}, ld_word};
    end

    // ALU
    always_comb begin
        case (alu_op_reg)
            OP_ADD:  alu_res = alu_a_reg + alu_b_reg;
            OP_SUB:  alu_res = alu_a_reg - alu_b_reg;
            OP_AND:  alu_res = alu_a_reg & alu_b_reg;
            OP_OR:   alu_res = alu_a_reg | alu_b_reg;
            default: alu_res = pass_v;
        endcase
    end

    // slot advance: load, address, issue, decode
    always_comb begin
        dec_vld_next  = dec_vld_reg;
        dec_ld_next   = dec_ld_reg;
        dec_op_next   = dec_op_reg;
        dec_dest_next = dec_dest_reg;
        dec_a_next    = dec_a_reg;
        dec_b_next    = dec_b_reg;
        alu_vld_next  = alu_vld_reg;
        alu_op_next   = alu_op_reg;
        alu_dest_next = alu_dest_reg;
        alu_a_next    = alu_a_reg;
        alu_b_next    = alu_b_reg;
        agu_vld_next  = agu_vld_reg;
        agu_dest_next = agu_dest_reg;
        agu_a_next    = agu_a_reg;
        agu_b_next    = agu_b_reg;
        ld_vld_next   = ld_vld_reg;
        ld_dest_next  = ld_dest_reg;
        ld_addr_next  = ld_addr_reg;
        if (exec_step) begin
            // address -> load
            ld_vld_next = agu_vld_reg;
            if (agu_vld_reg) begin
                ld_dest_next = agu_dest_reg;
                ld_addr_next = agu_a_reg + agu_b_reg;
            end
            // issue
            agu_vld_next = dec_vld_reg && dec_ld_reg;
            alu_vld_next = dec_vld_reg && !dec_ld_reg;
            if (dec_vld_reg && dec_ld_reg) begin
                agu_dest_next = dec_dest_reg;
                agu_a_next    = dec_a_reg[IDX_W-1:0];
                agu_b_next    = dec_b_reg[IDX_W-1:0];
            end
            if (dec_vld_reg && !dec_ld_reg) begin
                alu_op_next   = dec_op_reg;
                alu_dest_next = dec_dest_reg;
                alu_a_next    = dec_a_reg;
                alu_b_next    = dec_b_reg;
            end
            // decode
            dec_vld_next = x_item_reg.new_instr;
            if (x_item_reg.new_instr) begin
                dec_ld_next   = x_item_reg.is_load;
                dec_op_next   = x_item_reg.op;
                dec_dest_next = x_item_reg.dest;
                dec_a_next    = src1_v;
                dec_b_next    = src2_v;
            end
        end
    end

    // write-back queue: pop head, then push load result, then ALU result
    always_comb begin
        wbq_idx_next = wbq_idx_reg;
        wbq_val_next = wbq_val_reg;
        cnt0 = wbq_cnt_reg - CNT_W'(ret);
        for (int i = 0; i < WB_QUEUE_DEPTH - 1; i++) begin
            if (ret) begin
                wbq_idx_next[i] = wbq_idx_reg[i+1];
                wbq_val_next[i] = wbq_val_reg[i+1];
            end
        end
        cnt1 = cnt0;
        if (exec_step && ld_vld_reg && (cnt0 < CNT_W'(WB_QUEUE_DEPTH))) begin
            wbq_idx_next[cnt0[QI_W-1:0]] = ld_dest_reg;
            wbq_val_next[cnt0[QI_W-1:0]] = ld_value;
            cnt1 = cnt0 + 1'b1;
        end
        wbq_cnt_next = cnt1;
        if (exec_step && alu_vld_reg && (cnt1 < CNT_W'(WB_QUEUE_DEPTH))) begin
            wbq_idx_next[cnt1[QI_W-1:0]] = alu_dest_reg;
            wbq_val_next[cnt1[QI_W-1:0]] = alu_res;
            wbq_cnt_next = cnt1 + 1'b1;
        end
    end

    assign busy_next = dec_vld_next || alu_vld_next || agu_vld_next || ld_vld_next ||
                       (wbq_cnt_next != '0);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            dec_vld_reg <= 1'b0;
            alu_vld_reg <= 1'b0;
            agu_vld_reg <= 1'b0;
            ld_vld_reg  <= 1'b0;
            wbq_cnt_reg <= '0;
            rf_vld_reg  <= '0;
            dm_vld_reg  <= '0;
            rff_we_reg  <= 1'b0;
            dmf_we_reg  <= 1'b0;
        end else begin
            if (head_pop) begin
                x_valid_reg <= 1'b1;
            end else if (adv_x) begin
                x_valid_reg <= 1'b0;
            end
            if (adv_x) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            dec_vld_reg <= dec_vld_next;
            alu_vld_reg <= alu_vld_next;
            agu_vld_reg <= agu_vld_next;
            ld_vld_reg  <= ld_vld_next;
            wbq_cnt_reg <= wbq_cnt_next;
            if (rf_we) begin
                rf_vld_reg[RF_AW'(rf_widx)] <= 1'b1;
            end
            if (dm_we) begin
                dm_vld_reg[DM_AW'(x_item_reg.pidx)] <= 1'b1;
            end
            if (head_pop) begin
                rff_we_reg <= rf_we;
                dmf_we_reg <= dm_we;
            end
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        if (head_pop) begin
            x_item_reg  <= head;
            rff_idx_reg <= rf_widx;
            rff_val_reg <= rf_wval;
            dmf_idx_reg <= x_item_reg.pidx;
            dmf_val_reg <= x_item_reg.pval[WORD_W-1:0];
            rd1_vld_reg <= rf_vld_reg[RF_AW'(head.src1)];
            rd2_vld_reg <= rf_vld_reg[RF_AW'(head.src2)];
            rdb_vld_reg <= rf_vld_reg[RF_AW'(alu_dest_next)];
            dm_rvld_reg <= dm_vld_reg[DM_AW'(ld_addr_next)];
        end
        dec_ld_reg   <= dec_ld_next;
        dec_op_reg   <= dec_op_next;
        dec_dest_reg <= dec_dest_next;
        dec_a_reg    <= dec_a_next;
        dec_b_reg    <= dec_b_next;
        alu_op_reg   <= alu_op_next;
        alu_dest_reg <= alu_dest_next;
        alu_a_reg    <= alu_a_next;
        alu_b_reg    <= alu_b_next;
        agu_dest_reg <= agu_dest_next;
        agu_a_reg    <= agu_a_next;
        agu_b_reg    <= agu_b_next;
        ld_dest_reg  <= ld_dest_next;
        ld_addr_reg  <= ld_addr_next;
        wbq_idx_reg  <= wbq_idx_next;
        wbq_val_reg  <= wbq_val_next;
        if (adv_x) begin
            m_wbv_reg   <= ret;
            m_wbr_reg   <= ret ? ret_idx : '0;
            m_wbval_reg <= ret ? ret_val : '0;
            m_busy_reg  <= busy_next;
        end
    end

    // register file, copy A: source operand ports
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rfa_mem[RF_AW'(rf_widx)] <= rf_wval;
        end
        if (head_pop) begin
            rd1_data_reg <= rfa_mem[RF_AW'(head.src1)];
            rd2_data_reg <= rfa_mem[RF_AW'(head.src2)];
        end
    end

    // register file, copy B: pass-through destination port
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rfb_mem[RF_AW'(rf_widx)] <= rf_wval;
        end
        if (head_pop) begin
            rdb_data_reg <= rfb_mem[RF_AW'(alu_dest_next)];
        end
    end

    // data memory
    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[DM_AW'(x_item_reg.pidx)] <= x_item_reg.pval[WORD_W-1:0];
        end
        if (head_pop) begin
            dm_data_reg <= dm_mem[DM_AW'(ld_addr_next)];
        end
    end

    // result beat
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_wbv_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_busy_reg, m_wbval_reg, m_wbr_reg};

endmodule

FILE: sv/inorder_load_alu_pipeline.sv
// ----------------------------------------------------------------------------
// inorder_load_alu_pipeline
// In-order pipeline with a register file and data memory. Each step beat
// advances retire, load, ALU, address, issue and decode once; preload beats
// write a register or a memory word. One result beat per input beat.
// ----------------------------------------------------------------------------
// Path: an input beat passes the two-entry input queue, the execute register
//   and the output register. Throughput: one beat per cycle unless m_tready
//   stalls it; the execute stage does a whole step at once, with register file
//   and memory reads issued as the beat leaves the input queue.
// Reset: aresetn is synchronous, active low; it empties the queue and all
//   slots, and the register file and data memory read as zero until written.
module inorder_load_alu_pipeline
    import ilap_pkg::*;
#(
    parameter int NUM_REGS       = 8,
    parameter int DATA_WORDS     = 8,
    parameter int WB_QUEUE_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode, dest_reg, src1_reg, src2_reg, preload_index, preload_value, pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func, instr_valid
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // wb_reg, wb_value, busy_res, pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // wb_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic  head_valid;
    item_t head;
    logic  head_pop;

    // classify and queue
    ilap_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // execute
    ilap_back #(
        .NUM_REGS       (NUM_REGS),
        .DATA_WORDS     (DATA_WORDS),
        .WB_QUEUE_DEPTH (WB_QUEUE_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: tb/sv/inorder_load_alu_pipeline_test.sv
// ----------------------------------------------------------------------------
// inorder_load_alu_pipeline_test
// Self-checking bench for the in-order load/ALU pipeline. A shadow copy of
// the register file, data memory, pipeline slots and write-back queue is
// stepped on every accepted input beat to predict the write-back beat. Each
// output beat is checked field by field against the oldest prediction. The
// run is a short directed sequence, then random phases with varied idling.
// ----------------------------------------------------------------------------
module inorder_load_alu_pipeline_test;
    import ilap_pkg::*;

    // item function that the block ignores, and pass-through opcodes
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;
    localparam logic [OP_W-1:0]   OP_MOVE     = 3'd5;
    localparam logic [OP_W-1:0]   OP_MOVE_TOP = 3'd7;

    localparam int WB_DEPTH     = 4;
    localparam int PHASE_ITEMS  = 425;
    localparam int MAX_PRINTED  = 40;

    // one input beat, unpacked into its fields
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ivalid;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  dest;
        logic [IDX_W-1:0]  src1;
        logic [IDX_W-1:0]  src2;
        logic [IDX_W-1:0]  pidx;
        logic [VAL_W-1:0]  pval;
    } step_item_t;

    // one write-back beat
    typedef struct packed {
        logic             wb_valid;
        logic [IDX_W-1:0] wb_reg;
        logic [VAL_W-1:0] wb_value;
        logic             busy;
    } wb_result_t;

    // Shadow pipeline: steps on every accepted beat and queues the
    // write-back beat it expects; checks each output beat in order.
    class pipe_scoreboard;
        logic [VAL_W-1:0]  regs [8];
        logic [WORD_W-1:0] mem [8];

        bit               dec_v;
        logic [OP_W-1:0]  dec_op;
        logic [IDX_W-1:0] dec_dest;
        logic [VAL_W-1:0] dec_a, dec_b;

        bit               alu_v;
        logic [OP_W-1:0]  alu_op;
        logic [IDX_W-1:0] alu_dest;
        logic [VAL_W-1:0] alu_a, alu_b;

        bit               agu_v;
        logic [IDX_W-1:0] agu_dest;
        logic [VAL_W-1:0] agu_a, agu_b;

        bit               ld_v;
        logic [IDX_W-1:0] ld_dest;
        logic [IDX_W-1:0] ld_addr;

        logic [IDX_W-1:0] wbq_reg [$];
        logic [VAL_W-1:0] wbq_val [$];

        wb_result_t expected_wb [$];
        int         mismatches;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            dec_v = 0; dec_op = '0; dec_dest = '0; dec_a = '0; dec_b = '0;
            alu_v = 0; alu_op = '0; alu_dest = '0; alu_a = '0; alu_b = '0;
            agu_v = 0; agu_dest = '0; agu_a = '0; agu_b = '0;
            ld_v = 0; ld_dest = '0; ld_addr = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_wb.size();
        endfunction

        // full queue drops the push
        function void queue_writeback(logic [IDX_W-1:0] r, logic [VAL_W-1:0] v);
            if (wbq_reg.size() < WB_DEPTH) begin
                wbq_reg = {wbq_reg, r};
                wbq_val = {wbq_val, v};
            end
        endfunction

        function void note_item(step_item_t it);
            wb_result_t       res;
            logic [WORD_W-1:0] word;
            logic [VAL_W-1:0]  alu_out;
            logic [VAL_W-1:0]  addr_sum;
            res = '0;
            case (it.func)
                FUNC_PRE_REG: regs[it.pidx] = it.pval;
                FUNC_PRE_MEM: mem[it.pidx] = it.pval[WORD_W-1:0];
                FUNC_STEP: begin
                    // retire the queue head
                    if (wbq_reg.size() != 0) begin
                        res.wb_valid = 1'b1;
                        res.wb_reg   = wbq_reg.pop_front();
                        res.wb_value = wbq_val.pop_front();
                        regs[res.wb_reg] = res.wb_value;
                    end
                    // load, sign-extended
                    if (ld_v) begin
                        word = mem[ld_addr];
                        queue_writeback(ld_dest, {{(VAL_W-WORD_W){word[WORD_W-1]}}, word});
                        ld_v = 0;
                    end
                    // ALU; unknown opcodes pass the destination through
                    if (alu_v) begin
                        case (alu_op)
                            OP_ADD:  alu_out = alu_a + alu_b;
                            OP_SUB:  alu_out = alu_a - alu_b;
                            OP_AND:  alu_out = alu_a & alu_b;
                            OP_OR:   alu_out = alu_a | alu_b;
                            default: alu_out = regs[alu_dest];
                        endcase
                        queue_writeback(alu_dest, alu_out);
                        alu_v = 0;
                    end
                    // address: only the low bits index memory
                    if (agu_v) begin
                        addr_sum = agu_a + agu_b;
                        ld_v     = 1;
                        ld_dest  = agu_dest;
                        ld_addr  = addr_sum[IDX_W-1:0];
                        agu_v    = 0;
                    end
                    // issue
                    if (dec_v) begin
                        if (dec_op == OP_LD) begin
                            agu_v = 1; agu_dest = dec_dest; agu_a = dec_a; agu_b = dec_b;
                        end else begin
                            alu_v = 1; alu_op = dec_op; alu_dest = dec_dest;
                            alu_a = dec_a; alu_b = dec_b;
                        end
                        dec_v = 0;
                    end
                    // decode reads after this step's retire
                    if (it.ivalid) begin
                        dec_v    = 1;
                        dec_op   = it.op;
                        dec_dest = it.dest;
                        dec_a    = regs[it.src1];
                        dec_b    = regs[it.src2];
                    end
                end
                default: ;
            endcase
            res.busy = dec_v || alu_v || agu_v || ld_v || (wbq_reg.size() != 0);
            expected_wb = {expected_wb, res};
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTED)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_writeback(wb_result_t got);
            wb_result_t want;
            if (expected_wb.size() == 0) begin
                report_mismatch("write-back beat with nothing expected");
                return;
            end
            want = expected_wb.pop_front();
            if (got.wb_valid !== want.wb_valid)
                report_mismatch($sformatf("wb_valid %0b, want %0b",
                                          got.wb_valid, want.wb_valid));
            if (got.wb_reg !== want.wb_reg)
                report_mismatch($sformatf("wb_reg %0d, want %0d", got.wb_reg, want.wb_reg));
            if (got.wb_value !== want.wb_value)
                report_mismatch($sformatf("wb_value %h, want %h",
                                          got.wb_value, want.wb_value));
            if (got.busy !== want.busy)
                report_mismatch($sformatf("busy_res %0b, want %0b", got.busy, want.busy));
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    pipe_scoreboard sb = new;

    // idle and stall odds in percent, changed per stretch of beats
    int send_idle_now  = 0;
    int recv_stall_now = 0;

    inorder_load_alu_pipeline dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: check each accepted beat, then pick next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_writeback({m_tuser[0], m_tdata[IDX_W-1:0],
                                m_tdata[IDX_W +: VAL_W], m_tdata[IDX_W+VAL_W]});
        m_tready <= ($urandom_range(99) >= recv_stall_now);
    end

    function automatic step_item_t make_item(logic [FUNC_W-1:0] func, logic ivalid,
                                             logic [OP_W-1:0] op, logic [IDX_W-1:0] dest,
                                             logic [IDX_W-1:0] src1, logic [IDX_W-1:0] src2,
                                             logic [IDX_W-1:0] pidx, logic [VAL_W-1:0] pval);
        step_item_t it;
        it.func = func; it.ivalid = ivalid; it.op = op; it.dest = dest;
        it.src1 = src1; it.src2 = src2; it.pidx = pidx; it.pval = pval;
        return it;
    endfunction

    // values biased toward the corners of sign extension and wrap-around
    function automatic logic [VAL_W-1:0] corner_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {32'h0, 1'b1, 31'($urandom)};
            3:       return VAL_W'($urandom_range(15));
            4:       return {1'b1, 63'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly instructions, some preloads, empty steps and ignored items
    function automatic step_item_t random_item();
        step_item_t it;
        int         pick;
        it = make_item(FUNC_STEP, 1'b1, OP_W'($urandom_range(5)), IDX_W'($urandom),
                       IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                       corner_value());
        pick = $urandom_range(99);
        if (pick < 7)
            it.func = FUNC_PRE_REG;
        else if (pick < 14)
            it.func = FUNC_PRE_MEM;
        else if (pick < 16)
            it.func = FUNC_NONE;
        else if (pick < 24)
            it.ivalid = 1'b0;
        else if (pick < 44)
            it.op = OP_LD;
        else if (pick < 48)
            it.op = OP_W'($urandom_range(7));
        return it;
    endfunction

    task automatic send_item(input step_item_t it);
        logic [S_TDATA_W-1:0] data;
        logic [S_TUSER_W-1:0] user;
        data = '0;
        data[S_OPCODE_LSB +: OP_W] = it.op;
        data[S_DEST_LSB +: IDX_W]  = it.dest;
        data[S_SRC1_LSB +: IDX_W]  = it.src1;
        data[S_SRC2_LSB +: IDX_W]  = it.src2;
        data[S_PIDX_LSB +: IDX_W]  = it.pidx;
        data[S_PVAL_LSB +: VAL_W]  = it.pval;
        user = '0;
        user[S_FUNC_LSB +: FUNC_W] = it.func;
        user[S_IVALID_BIT]         = it.ivalid;
        while ($urandom_range(99) < send_idle_now) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= user;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(it);
    endtask

    // hold the sender until every expected beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int count);
        bit quiet;
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 0) begin
                quiet          = ($urandom_range(3) == 0);
                send_idle_now  = quiet ? 0 : send_pct;
                recv_stall_now = quiet ? 0 : recv_pct;
            end
            send_item(random_item());
        end
        wait_drained();
    endtask

    // stimulus
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: corner operands, ALU, load and two pass-through opcodes, load address wrap,
        // sign extension, decode without hazard checks, preload mid-stream
        send_item(make_item(FUNC_PRE_REG, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd0, '1));
        send_item(make_item(FUNC_PRE_REG, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd1, {1'b1, 63'h0}));
        send_item(make_item(FUNC_PRE_REG, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd2, 64'd1));
        send_item(make_item(FUNC_PRE_REG, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd7, {1'b0, {63{1'b1}}}));
        send_item(make_item(FUNC_PRE_MEM, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd6,
                            64'hFFFF_FFFF_8000_0001));
        send_item(make_item(FUNC_PRE_MEM, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd7,
                            64'h0000_0000_7FFF_FFFF));
        send_item(make_item(FUNC_PRE_MEM, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd0,
                            64'h1234_5678_FFFF_FFFF));
        send_item(make_item(FUNC_STEP, 1'b1, OP_ADD, 3'd3, 3'd0, 3'd2, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_SUB, 3'd4, 3'd2, 3'd0, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_AND, 3'd5, 3'd0, 3'd1, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_OR,  3'd6, 3'd7, 3'd1, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_LD,  3'd5, 3'd7, 3'd7, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_LD,  3'd6, 3'd0, 3'd1, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_LD,  3'd1, 3'd0, 3'd2, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_MOVE, 3'd2, 3'd5, 3'd6, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_MOVE_TOP, 3'd0, 3'd1, 3'd2, 3'd0, '0));
        send_item(make_item(FUNC_STEP, 1'b1, OP_ADD, 3'd4, 3'd3, 3'd5, 3'd0, '0));
        send_item(make_item(FUNC_PRE_REG, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd3, '0));
        send_item(make_item(FUNC_NONE, 1'b1, OP_OR, 3'd7, 3'd7, 3'd7, 3'd7, '1));
        repeat (6)
            send_item(make_item(FUNC_STEP, 1'b0, OP_ADD, 3'd0, 3'd0, 3'd0, 3'd0, '0));
        wait_drained();

        // random phases, each drained before the next
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(68, 0, PHASE_ITEMS);
        run_phase(0, 68, PHASE_ITEMS);
        run_phase(18, 18, PHASE_ITEMS);

        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
